FILE: hdl/abfind_pkg.sv
// ----------------------------------------------------------------------------
// abfind_pkg
// Shared types, codes and helpers for the allocation bitmap find-first block.
// ----------------------------------------------------------------------------
package abfind_pkg;

  localparam int WORD_BITS = 64;
  localparam int OFF_W     = 6;
  localparam int IDX_W     = 12;
  localparam int LIM_W     = 13;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = OFF_W'(i);
      end
    end
    return p;
  endfunction

endpackage

FILE: hdl/abfind_mem.sv
// ----------------------------------------------------------------------------
// abfind_mem
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module abfind_mem import abfind_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  mem_cmd_t             cmd,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/abfind_ctrl.sv
// ----------------------------------------------------------------------------
// abfind_ctrl
// Request sequencer: clearing pass, bit read-modify-write and word scan.
// ----------------------------------------------------------------------------
module abfind_ctrl import abfind_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           req_type,
  input  logic [IDX_W-1:0]     bit_index,
  input  logic                 bit_value,
  input  logic [LIM_W-1:0]     limit,
  output logic                 busy,
  output logic                 done,
  output logic                 bit_read,
  output logic                 in_range,
  output logic                 found,
  output logic [IDX_W-1:0]     found_index,
  output mem_cmd_t             cmd,
  output logic [AW-1:0]        rd_addr,
  output logic [AW-1:0]        wr_addr,
  output logic [WORD_BITS-1:0] wr_data,
  input  logic [WORD_BITS-1:0] rd_data
);

  state_t state, state_next;
  logic [AW-1:0]    clr_addr;
  logic [AW-1:0]    chk;
  logic [1:0]       op;
  logic [IDX_W-1:0] idx;
  logic             val;

  logic             done_next, bit_read_next, in_range_next, found_next;
  logic [IDX_W-1:0] found_index_next;

  logic                 acc, inr_in, inr_r, at_last, hit, limit_zero;
  logic [AW-1:0]        last_word;
  logic [WORD_BITS-1:0] mask, hit_vec, bit_mask;
  logic [OFF_W-1:0]     pos;

  assign busy       = (state != S_IDLE);
  assign acc        = start && (state == S_IDLE);
  assign limit_zero = (limit == '0);
  assign inr_in     = ({1'b0, bit_index} < limit);
  assign inr_r      = ({1'b0, idx} < limit);
  assign last_word  = AW'((limit - LIM_W'(1)) >> OFF_W);
  assign at_last    = (chk == last_word);
  assign mask       = (at_last && (limit[OFF_W-1:0] != '0)) ?
                      ((WORD_BITS'(1) << limit[OFF_W-1:0]) - WORD_BITS'(1)) : '1;
  assign hit_vec    = (val ? rd_data : ~rd_data) & mask;
  assign hit        = |hit_vec;
  assign pos        = lowest_set(hit_vec);
  assign bit_mask   = WORD_BITS'(1) << idx[OFF_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_READ, REQ_WRITE: state_next = S_ACCESS;
            REQ_FIND: state_next = limit_zero ? S_IDLE : S_SCAN;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ACCESS: state_next = S_IDLE;
      S_SCAN: begin
        if (hit || at_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd              = '0;
    rd_addr          = chk + AW'(1);
    wr_addr          = clr_addr;
    wr_data          = '0;
    done_next        = 1'b0;
    bit_read_next    = 1'b0;
    in_range_next    = 1'b0;
    found_next       = 1'b0;
    found_index_next = '0;
    case (state)
      S_CLEAR: begin
        cmd.wr = 1'b1;
      end
      S_IDLE: begin
        rd_addr = AW'(bit_index[IDX_W-1:OFF_W]);
        if (start) begin
          case (req_type)
            REQ_READ, REQ_WRITE: cmd.rd = inr_in;
            REQ_FIND: begin
              rd_addr   = '0;
              cmd.rd    = !limit_zero;
              done_next = limit_zero;
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      S_ACCESS: begin
        done_next     = 1'b1;
        in_range_next = inr_r;
        if (op == REQ_READ) begin
          bit_read_next = inr_r && rd_data[idx[OFF_W-1:0]];
        end
        if (op == REQ_WRITE && inr_r) begin
          cmd.wr  = 1'b1;
          wr_addr = AW'(idx[IDX_W-1:OFF_W]);
          wr_data = val ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        end
      end
      S_SCAN: begin
        if (hit) begin
          done_next        = 1'b1;
          found_next       = 1'b1;
          found_index_next = IDX_W'({chk, pos});
        end else if (at_last) begin
          done_next = 1'b1;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    bit_read    <= bit_read_next;
    in_range    <= in_range_next;
    found       <= found_next;
    found_index <= found_index_next;
    if (acc) begin
      op  <= req_type;
      idx <= bit_index;
      val <= bit_value;
      chk <= '0;
    end else if (state == S_SCAN) begin
      chk <= chk + AW'(1);
    end
  end

  a_access_done: assert property (@(posedge clk) disable iff (rst)
    state == S_ACCESS |=> done)
    else $error("bit access gave no result beat");

  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    done && found |-> !bit_read && !in_range)
    else $error("find beat carries bit access fields");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> chk <= last_word)
    else $error("scan passed the last live word");

  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> !acc)
    else $error("store written while a request is taken");

endmodule

FILE: hdl/allocation_bitmap_find_first.sv
// ----------------------------------------------------------------------------
// allocation_bitmap_find_first
// Allocation bitmap with bit read, bit write and find-first-match requests.
// ----------------------------------------------------------------------------
// A request beat (req_type, bit_index, bit_value) is taken at a clock edge
// with start high and busy low. Each request gives exactly one result beat,
// flagged by done for a single cycle; the receiver cannot hold it off.
// Read and write: the store word is read as the request is taken and the
// result formed in the access state; the write lands in the store as the
// result is formed, so busy drops with done. Find: the map is held as 64-bit
// words, one word examined per cycle through the store's single read port,
// from word 0 up to the last live word, stopping at the first match.
// A find with no live bits and the unused request code answer in the cycle
// after the request, with busy staying low.
// bits_in_use is written through cfg_we / cfg_data; the user must do so only
// while no request is open, as the block itself does not enforce it. Values
// above MAX_BITS act as MAX_BITS. After reset a clearing pass zeroes the
// store, one word per cycle, with busy held high; configuration writes are
// taken throughout.
// ----------------------------------------------------------------------------
module allocation_bitmap_find_first import abfind_pkg::*; #(
  parameter int MAX_BITS = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [IDX_W-1:0] bit_index,
  input  logic             bit_value,
  input  logic             cfg_we,
  input  logic [LIM_W-1:0] cfg_data,
  output logic             done,
  output logic             bit_read,
  output logic             in_range,
  output logic             found,
  output logic [IDX_W-1:0] found_index
);

  localparam int DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LIM_W-1:0] CAP =
    (MAX_BITS > 8191) ? {LIM_W{1'b1}} : LIM_W'(MAX_BITS);

  logic [LIM_W-1:0]     bits_in_use;
  logic [LIM_W-1:0]     limit;
  mem_cmd_t             cmd;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= LIMIT_RESET;
    end else if (cfg_we) begin
      bits_in_use <= cfg_data;
    end
  end

  assign limit = (bits_in_use > CAP) ? CAP : bits_in_use;

  abfind_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .bit_index  (bit_index),
    .bit_value  (bit_value),
    .limit      (limit),
    .busy       (busy),
    .done       (done),
    .bit_read   (bit_read),
    .in_range   (in_range),
    .found      (found),
    .found_index(found_index),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_data    (rd_data)
  );

  abfind_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .cmd    (cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for allocation_bitmap_find_first: a directed table of
// reads, writes and finds at the edges of the map and of the live limit, then
// random phases at several live limits. Every accepted request is run through
// a bit-level predictor and each result beat is compared with the oldest
// expected answer.
// ----------------------------------------------------------------------------
module tb import abfind_pkg::*; ();

  localparam int               MAP_BITS     = 4096;
  localparam logic [1:0]       REQ_UNUSED   = 2'd3;
  localparam logic [LIM_W-1:0] LIMIT_MAX    = 13'd8191;
  localparam int               CYCLE_LIMIT  = 400000;
  localparam int               DRAIN_CYCLES = 80;
  localparam int               PHASES       = 8;
  localparam int               PHASE_ITEMS  = 112;

  typedef struct packed {
    logic             bit_read;
    logic             in_range;
    logic             found;
    logic [IDX_W-1:0] found_index;
  } answer_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [1:0]       req;
    logic [IDX_W-1:0] idx;
    logic             val;
    logic [LIM_W-1:0] limit;
    logic             typed;
    answer_t          ans;
  } script_row_t;

  localparam answer_t ANS_NONE   = '0;
  localparam answer_t ANS_IN     = '{1'b0, 1'b1, 1'b0, 12'd0};
  localparam answer_t ANS_ONE_IN = '{1'b1, 1'b1, 1'b0, 12'd0};
  localparam answer_t ANS_AT0    = '{1'b0, 1'b0, 1'b1, 12'd0};

  localparam int SCRIPT_LEN = 29;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_REQ, REQ_READ,   12'd0,    1'b0, 13'd0,    1'b1, ANS_IN},
    '{ROW_REQ, REQ_READ,   12'd4095, 1'b0, 13'd0,    1'b1, ANS_IN},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b1, 13'd0,    1'b1, ANS_NONE},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b0, 13'd0,    1'b1, ANS_AT0},
    '{ROW_REQ, REQ_WRITE,  12'd4095, 1'b1, 13'd0,    1'b1, ANS_IN},
    '{ROW_REQ, REQ_READ,   12'd4095, 1'b0, 13'd0,    1'b1, ANS_ONE_IN},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b1, 13'd0,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_WRITE,  12'd0,    1'b1, 13'd0,    1'b1, ANS_IN},
    '{ROW_REQ, REQ_FIND,   12'd4095, 1'b0, 13'd0,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_UNUSED, 12'd4095, 1'b1, 13'd0,    1'b1, ANS_NONE},
    '{ROW_REQ, REQ_READ,   12'd0,    1'b1, 13'd0,    1'b0, ANS_NONE},
    '{ROW_CFG, REQ_READ,   12'd0,    1'b0, LIMIT_MAX, 1'b0, ANS_NONE},
    '{ROW_REQ, REQ_READ,   12'd4095, 1'b0, 13'd0,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b1, 13'd0,    1'b0, ANS_NONE},
    '{ROW_CFG, REQ_READ,   12'd0,    1'b0, 13'd0,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_READ,   12'd0,    1'b0, 13'd0,    1'b1, ANS_NONE},
    '{ROW_REQ, REQ_WRITE,  12'd0,    1'b0, 13'd0,    1'b1, ANS_NONE},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b0, 13'd0,    1'b1, ANS_NONE},
    '{ROW_CFG, REQ_READ,   12'd0,    1'b0, 13'd9,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_WRITE,  12'd8,    1'b1, 13'd0,    1'b1, ANS_IN},
    '{ROW_REQ, REQ_WRITE,  12'd9,    1'b1, 13'd0,    1'b1, ANS_NONE},
    '{ROW_REQ, REQ_WRITE,  12'd0,    1'b0, 13'd0,    1'b1, ANS_IN},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b1, 13'd0,    1'b0, ANS_NONE},
    '{ROW_CFG, REQ_READ,   12'd0,    1'b0, LIMIT_RESET, 1'b0, ANS_NONE},
    '{ROW_REQ, REQ_READ,   12'd9,    1'b0, 13'd0,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b0, 13'd0,    1'b0, ANS_NONE},
    '{ROW_CFG, REQ_READ,   12'd0,    1'b0, 13'd1,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b1, 13'd0,    1'b0, ANS_NONE},
    '{ROW_REQ, REQ_FIND,   12'd0,    1'b0, 13'd0,    1'b0, ANS_NONE}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       req_type = REQ_READ;
  logic [IDX_W-1:0] bit_index = '0;
  logic             bit_value = 1'b0;
  logic             cfg_we = 1'b0;
  logic [LIM_W-1:0] cfg_data = '0;
  logic             done;
  logic             bit_read;
  logic             in_range;
  logic             found;
  logic [IDX_W-1:0] found_index;

  bit               map_bits [MAP_BITS];
  logic [LIM_W-1:0] live_bits = LIMIT_RESET;
  answer_t          answer_q [$];
  bit               failed = 1'b0;
  int               burst_left = 0;
  int               cycles = 0;

  allocation_bitmap_find_first dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .bit_index   (bit_index),
    .bit_value   (bit_value),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .done        (done),
    .bit_read    (bit_read),
    .in_range    (in_range),
    .found       (found),
    .found_index (found_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int live_limit();
    return (int'(live_bits) > MAP_BITS) ? MAP_BITS : int'(live_bits);
  endfunction

  function automatic answer_t predict_answer(input logic [1:0] req,
                                             input logic [IDX_W-1:0] idx,
                                             input logic val);
    answer_t a;
    int      lim;
    a   = '0;
    lim = live_limit();
    case (req)
      REQ_READ: begin
        a.in_range = int'(idx) < lim;
        a.bit_read = a.in_range && map_bits[idx];
      end
      REQ_WRITE: begin
        if (int'(idx) < lim) begin
          a.in_range    = 1'b1;
          map_bits[idx] = val;
        end
      end
      REQ_FIND: begin
        for (int j = 0; j < lim && !a.found; j++) begin
          if (map_bits[j] == val) begin
            a.found       = 1'b1;
            a.found_index = IDX_W'(j);
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic issue_request(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                               input logic val, input logic typed, input answer_t ans);
    int      gap;
    answer_t want;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 16);
    end
    start     <= 1'b1;
    req_type  <= req;
    bit_index <= idx;
    bit_value <= val;
    do @(posedge clk); while (busy);
    burst_left--;
    want = predict_answer(req, idx, val);
    answer_q.push_back(typed ? ans : want);
  endtask

  task automatic settle_and_configure(input logic [LIM_W-1:0] limit);
    start <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0 || busy);
    cfg_we   <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
    live_bits = limit;
  endtask

  always @(posedge clk) begin : result_check
    answer_t want;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $error("result beat with no request outstanding");
        failed = 1'b1;
      end else begin
        want = answer_q.pop_front();
        if (bit_read !== want.bit_read) begin
          $error("bit_read: expected %0d, got %0d", want.bit_read, bit_read);
          failed = 1'b1;
        end
        if (in_range !== want.in_range) begin
          $error("in_range: expected %0d, got %0d", want.in_range, in_range);
          failed = 1'b1;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          failed = 1'b1;
        end
        if (found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, found_index);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [LIM_W-1:0] limit;
    logic [1:0]       req;
    logic [IDX_W-1:0] idx;
    logic             val;
    int               lim;
    int               ones_pct;
    int               pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        settle_and_configure(SCRIPT[i].limit);
      end else begin
        issue_request(SCRIPT[i].req, SCRIPT[i].idx, SCRIPT[i].val, SCRIPT[i].typed,
                      SCRIPT[i].ans);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: limit = LIMIT_MAX;
        1: limit = LIM_W'($urandom_range(1, 300));
        2: limit = LIMIT_RESET;
        3: limit = LIM_W'($urandom_range(8, 100));
        4: limit = '0;
        5: limit = LIM_W'($urandom_range(0, 8191));
        6: limit = LIM_W'($urandom_range(1, 40));
        default: limit = 13'd4095;
      endcase
      settle_and_configure(limit);
      lim = live_limit();
      case ($urandom_range(0, 2))
        0: ones_pct = 5;
        1: ones_pct = 50;
        default: ones_pct = 95;
      endcase
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          req = REQ_WRITE;
        end else if (pick < 65) begin
          req = REQ_READ;
        end else if (pick < 95) begin
          req = REQ_FIND;
        end else begin
          req = REQ_UNUSED;
        end
        pick = $urandom_range(0, 9);
        if (lim > 0 && pick < 8) begin
          idx = IDX_W'($urandom_range(0, lim - 1));
        end else if (lim > 0 && pick == 8) begin
          idx = IDX_W'(lim - 1 + $urandom_range(0, 1));
        end else begin
          idx = IDX_W'($urandom);
        end
        if (req == REQ_WRITE) begin
          val = $urandom_range(0, 99) < ones_pct;
        end else begin
          val = $urandom_range(0, 1);
        end
        issue_request(req, idx, val, 1'b0, ANS_NONE);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && answer_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/abfind_pkg.sv
hdl/abfind_mem.sv
hdl/abfind_ctrl.sv
hdl/allocation_bitmap_find_first.sv
tb/tb.sv
